// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is low
`define KSPD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also runs through reset
`define KSPD_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/kspd_pkg.sv
// Shared types and constants of the knock-on source pitch deposit block.
// No dependencies.
package kspd_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID = 2'd1;

    localparam logic [63:0] Q_ONE   = 64'h0000_0001_0000_0000;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        AOP_MUL,
        AOP_DIV,
        AOP_SQRT
    } t_aop;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_RT, S_XI, S_SRCH, S_SCMP,
        S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
        S_C0, S_C1, S_C2, S_DL, S_PREP,
        S_LOM, S_LOD, S_UPM, S_UPD, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        ST_NONE, ST_SQ, ST_RT, ST_XI, ST_SRD, ST_SCMP,
        ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4,
        ST_C0, ST_C1, ST_C2, ST_DL, ST_PREP,
        ST_LOM, ST_LOD, ST_UPM, ST_UPD, ST_OUT
    } t_step;

    typedef struct packed {
        t_step step;
        logic  start;
        logic  take;
    } t_cmd;

    typedef struct packed {
        logic arith_done;
        logic search_done;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic        done;
        logic [63:0] val;
        logic        sat;
        logic [63:0] root;
    } t_ares;

endpackage

// File: rtl/kspd_grid_ram.sv
// Pitch grid table: one write port, one registered read port.
// Depends on nothing.
module kspd_grid_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [33:0]   i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic signed [33:0]   o_rdata
);

    logic signed [33:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/kspd_arith.sv
// Shared iterative unit: shift-add multiply, restoring divide, digit square root.
// Applies sign and saturation to the Q32.32 result. Uses kspd_pkg.
module kspd_arith (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  kspd_pkg::t_aop    i_op,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    input  logic              i_neg,
    output kspd_pkg::t_ares   o_res
);

    logic            r_busy, r_done, r_neg, r_dz;
    kspd_pkg::t_aop  r_op;
    logic [6:0]      r_cnt;
    logic [127:0]    r_p;
    logic [63:0]     r_b;
    logic [67:0]     r_rem;
    logic [63:0]     r_root;

    logic [64:0] mul_sum;
    logic [67:0] sq_sh, sq_trial;
    logic        sq_ge;
    logic [64:0] dv_t, dv_diff;
    logic        dv_ge;

    always_comb begin
        mul_sum  = {1'b0, r_p[127:64]} + (r_p[0] ? {1'b0, r_b} : 65'd0);
        sq_sh    = {r_rem[65:0], r_p[127:126]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
        dv_t     = {r_rem[63:0], r_p[95]};
        dv_diff  = dv_t - {1'b0, r_b};
        dv_ge    = dv_t >= {1'b0, r_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                r_neg  <= i_neg;
                r_dz   <= 1'b0;
                r_rem  <= '0;
                case (i_op)
                    kspd_pkg::AOP_MUL: begin
                        r_p   <= {64'd0, i_b};
                        r_b   <= i_a;
                        r_cnt <= 7'd63;
                    end
                    kspd_pkg::AOP_SQRT: begin
                        // radicand is the last product plus one at Q.64 scale
                        r_p    <= {r_p[127:64] + 64'd1, r_p[63:0]};
                        r_root <= '0;
                        r_cnt  <= 7'd63;
                    end
                    default: begin
                        r_p   <= {32'd0, i_a, 32'd0};
                        r_b   <= i_b;
                        r_dz  <= (i_b == 64'd0);
                        r_cnt <= 7'd95;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    kspd_pkg::AOP_MUL: begin
                        r_p <= {mul_sum, r_p[63:1]};
                    end
                    kspd_pkg::AOP_SQRT: begin
                        r_rem  <= sq_ge ? sq_sh - sq_trial : sq_sh;
                        r_root <= {r_root[62:0], sq_ge};
                        r_p    <= {r_p[125:0], 2'b00};
                    end
                    default: begin
                        r_rem     <= dv_ge ? {4'd0, dv_diff[63:0]} : {4'd0, dv_t[63:0]};
                        r_p[95:0] <= {r_p[94:0], dv_ge};
                    end
                endcase
                if (r_cnt == 7'd0 || r_dz) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end

    logic [95:0] m;
    logic [63:0] lim;
    logic        ovf;

    always_comb begin
        m   = (r_op == kspd_pkg::AOP_MUL) ? r_p[127:32] : r_p[95:0];
        lim = r_neg ? kspd_pkg::S64_MIN : kspd_pkg::S64_MAX;
        ovf = (m[95:64] != 32'd0) || (m[63:0] > lim);
        o_res.done = r_done;
        o_res.root = r_root;
        if (r_dz || ovf) begin
            o_res.sat = 1'b1;
            o_res.val = r_neg ? kspd_pkg::S64_MIN : kspd_pkg::S64_MAX;
        end else begin
            o_res.sat = 1'b0;
            o_res.val = r_neg ? 64'd0 - m[63:0] : m[63:0];
        end
    end

endmodule

// File: rtl/kspd_datapath.sv
// Datapath: configuration, grid table, search indexes, working values, result beat.
// Uses kspd_pkg, kspd_grid_ram and kspd_arith.
module kspd_datapath #(
    parameter int MAX_PITCH_POINTS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kspd_pkg::t_cmd                   i_cmd,
    output kspd_pkg::t_stat                  o_stat,
    input  logic                             i_cfg_we,
    input  logic [kspd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [62:0]                      i_cfg_data,
    input  logic                             i_kind,
    input  logic [7:0]                       i_grid_index,
    input  logic signed [33:0]               i_grid_value,
    input  logic [62:0]                      i_momentum,
    input  logic [15:0]                      i_velocity_slot,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [15:0]                      o_slot_out,
    output logic [7:0]                       o_lower_cell,
    output logic signed [63:0]               o_lower_source,
    output logic signed [63:0]               o_upper_source,
    output logic                             o_saturated,
    output logic                             o_positive_pitch
);

    localparam int AW  = $clog2(MAX_PITCH_POINTS);
    localparam int NPW = AW + 1;

    function automatic logic signed [63:0] half_tz(input logic signed [63:0] x);
        logic signed [63:0] s;
        s = x + 64'(x[63]);
        return s >>> 1;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : x;
    endfunction

    logic [62:0]  r_beta;
    logic [8:0]   r_gp;
    logic [62:0]  r_v;
    logic [15:0]  r_slot;
    logic [63:0]  r_g;
    logic [AW-1:0] r_jl, r_ju;
    logic [NPW-1:0] r_np;
    logic signed [63:0] r_xi, r_y0, r_y1, r_ym, r_y2;
    logic signed [63:0] r_c, r_delta, r_omd, r_hylo, r_hyup, r_t, r_lo, r_up;
    logic r_sat;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= '0;
            r_gp   <= 9'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kspd_pkg::CFG_BETA: r_beta <= i_cfg_data;
                kspd_pkg::CFG_GRID: r_gp   <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // grid table
    logic              ram_we;
    logic [AW-1:0]     raddr;
    logic signed [33:0] rdata;
    logic signed [63:0] rd64;
    logic [NPW:0]      jm_sum;
    logic [AW-1:0]     jm;

    assign ram_we = i_cmd.take && !i_kind && (int'(i_grid_index) < MAX_PITCH_POINTS);
    assign rd64   = 64'(rdata);
    assign jm_sum = {2'b00, r_ju} + {2'b00, r_jl};
    assign jm     = jm_sum[AW:1];

    always_comb begin
        case (i_cmd.step)
            kspd_pkg::ST_SRD: raddr = jm;
            kspd_pkg::ST_RD1: raddr = r_jl + AW'(1);
            kspd_pkg::ST_RD2: raddr = r_jl - AW'(1);
            kspd_pkg::ST_RD3: raddr = r_jl + AW'(2);
            default:          raddr = r_jl;
        endcase
    end

    kspd_grid_ram #(
        .DEPTH (MAX_PITCH_POINTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_grid_index)),
        .i_wdata (i_grid_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // operand selection for the shared unit
    kspd_pkg::t_aop  aop;
    logic [63:0]     opa, opb;
    logic            opneg;
    kspd_pkg::t_ares ares;
    logic signed [63:0] dxy, dy;

    assign dxy = r_xi - r_y0;
    assign dy  = r_y1 - r_y0;

    always_comb begin
        aop   = kspd_pkg::AOP_DIV;
        opa   = '0;
        opb   = '0;
        opneg = 1'b0;
        case (i_cmd.step)
            kspd_pkg::ST_SQ: begin
                aop = kspd_pkg::AOP_MUL;
                opa = {1'b0, r_v};
                opb = {1'b0, r_v};
            end
            kspd_pkg::ST_RT: aop = kspd_pkg::AOP_SQRT;
            kspd_pkg::ST_XI: begin
                opa   = {1'b0, r_v};
                opb   = r_g + kspd_pkg::Q_ONE;
                opneg = 1'b1;
            end
            kspd_pkg::ST_C0: begin
                opa = {2'b00, r_beta[62:1]};
                opb = r_g;
            end
            kspd_pkg::ST_C1, kspd_pkg::ST_C2: begin
                opa = r_c;
                opb = r_g - kspd_pkg::Q_ONE;
            end
            kspd_pkg::ST_DL: begin
                opa   = mag64(dxy);
                opb   = mag64(dy);
                opneg = dy[63];
            end
            kspd_pkg::ST_LOM: begin
                aop   = kspd_pkg::AOP_MUL;
                opa   = mag64(r_c);
                opb   = mag64(r_omd);
                opneg = r_c[63] ^ r_omd[63];
            end
            kspd_pkg::ST_UPM: begin
                aop   = kspd_pkg::AOP_MUL;
                opa   = mag64(r_c);
                opb   = mag64(r_delta);
                opneg = r_c[63] ^ r_delta[63];
            end
            kspd_pkg::ST_LOD: begin
                opa   = mag64(r_t);
                opb   = mag64(r_hylo);
                opneg = (r_hylo == 64'sd0) ? r_t[63] : (r_t[63] ^ r_hylo[63]);
            end
            kspd_pkg::ST_UPD: begin
                opa   = mag64(r_t);
                opb   = mag64(r_hyup);
                opneg = (r_hyup == 64'sd0) ? r_t[63] : (r_t[63] ^ r_hyup[63]);
            end
            default: ;
        endcase
    end

    kspd_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_op    (aop),
        .i_a     (opa),
        .i_b     (opb),
        .i_neg   (opneg),
        .o_res   (ares)
    );

    // grid size clamp and cell-edge tests
    logic [NPW-1:0] npv;
    logic           jl_zero, jl_last;
    logic signed [64:0] od;
    logic           od_ovf;
    logic signed [63:0] n_omd, n_hylo, n_hyup;

    always_comb begin
        if (r_gp < 9'd3) begin
            npv = NPW'(3);
        end else if (int'(r_gp) > MAX_PITCH_POINTS) begin
            npv = NPW'(MAX_PITCH_POINTS);
        end else begin
            npv = NPW'(r_gp);
        end
        jl_zero = (r_jl == '0);
        jl_last = (({1'b0, r_jl} + NPW'(2)) == r_np);
        od      = {1'b0, kspd_pkg::Q_ONE} - {r_delta[63], r_delta};
        od_ovf  = od[64] != od[63];
        if (od_ovf) begin
            n_omd = od[64] ? kspd_pkg::S64_MIN : kspd_pkg::S64_MAX;
        end else begin
            n_omd = od[63:0];
        end
        n_hylo = jl_zero ? half_tz(dy) + r_y0 + kspd_pkg::Q_ONE : half_tz(r_y1 - r_ym);
        n_hyup = jl_last ? half_tz(dy) - r_y1 : half_tz(r_y2 - r_y0);
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_kind) begin
            r_v    <= i_momentum;
            r_slot <= i_velocity_slot;
            r_sat  <= 1'b0;
            r_np   <= npv;
            r_jl   <= '0;
            r_ju   <= AW'(npv - NPW'(1));
        end
        case (i_cmd.step)
            kspd_pkg::ST_SCMP: begin
                if (r_xi >= rd64) r_jl <= jm;
                else              r_ju <= jm;
            end
            kspd_pkg::ST_RD1: r_y0 <= rd64;
            kspd_pkg::ST_RD2: r_y1 <= rd64;
            kspd_pkg::ST_RD3: r_ym <= rd64;
            kspd_pkg::ST_RD4: r_y2 <= rd64;
            kspd_pkg::ST_PREP: begin
                r_omd  <= n_omd;
                r_hylo <= n_hylo;
                r_hyup <= n_hyup;
                r_sat  <= r_sat | od_ovf;
            end
            default: ;
        endcase
        if (ares.done) begin
            case (i_cmd.step)
                kspd_pkg::ST_RT: r_g  <= ares.root;
                kspd_pkg::ST_XI: r_xi <= ares.val;
                kspd_pkg::ST_C0, kspd_pkg::ST_C1, kspd_pkg::ST_C2: r_c <= ares.val;
                kspd_pkg::ST_DL: r_delta <= ares.val;
                kspd_pkg::ST_LOM, kspd_pkg::ST_UPM: r_t <= ares.val;
                kspd_pkg::ST_LOD: r_lo <= ares.val;
                kspd_pkg::ST_UPD: r_up <= ares.val;
                default: ;
            endcase
            // square, root and xi never clamp in a way that counts
            if (!(i_cmd.step inside {kspd_pkg::ST_SQ, kspd_pkg::ST_RT, kspd_pkg::ST_XI})) begin
                r_sat <= r_sat | ares.sat;
            end
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.step == kspd_pkg::ST_OUT) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step == kspd_pkg::ST_OUT) begin
            o_slot_out       <= r_slot;
            o_lower_cell     <= 8'(r_jl);
            o_lower_source   <= r_lo;
            o_upper_source   <= r_up;
            o_saturated      <= r_sat;
            o_positive_pitch <= !r_y0[63];
        end
    end

    assign o_stat.arith_done  = ares.done;
    assign o_stat.search_done = (r_ju - r_jl) <= AW'(1);
    assign o_stat.out_free    = !o_out_valid || i_out_ready;

endmodule

// File: rtl/kspd_ctrl.sv
// Controller: sequences one evaluate item through the shared unit and the table.
// Uses kspd_pkg.
module kspd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_kind,
    input  kspd_pkg::t_stat   i_stat,
    output logic              o_in_ready,
    output kspd_pkg::t_cmd    o_cmd
);

    kspd_pkg::t_state r_state, n_state;
    logic r_issued, n_issued;
    logic is_op;

    always_comb begin
        is_op = r_state inside {kspd_pkg::S_SQ, kspd_pkg::S_RT, kspd_pkg::S_XI,
                                kspd_pkg::S_C0, kspd_pkg::S_C1, kspd_pkg::S_C2,
                                kspd_pkg::S_DL, kspd_pkg::S_LOM, kspd_pkg::S_LOD,
                                kspd_pkg::S_UPM, kspd_pkg::S_UPD};
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_issued = r_issued;
        if (is_op) begin
            if (!r_issued) n_issued = 1'b1;
            if (i_stat.arith_done) n_issued = 1'b0;
        end
        case (r_state)
            kspd_pkg::S_IDLE: if (i_in_valid && i_kind) n_state = kspd_pkg::S_SQ;
            kspd_pkg::S_SQ:   if (i_stat.arith_done) n_state = kspd_pkg::S_RT;
            kspd_pkg::S_RT:   if (i_stat.arith_done) n_state = kspd_pkg::S_XI;
            kspd_pkg::S_XI:   if (i_stat.arith_done) n_state = kspd_pkg::S_SRCH;
            kspd_pkg::S_SRCH: n_state = i_stat.search_done ? kspd_pkg::S_RD0 : kspd_pkg::S_SCMP;
            kspd_pkg::S_SCMP: n_state = kspd_pkg::S_SRCH;
            kspd_pkg::S_RD0:  n_state = kspd_pkg::S_RD1;
            kspd_pkg::S_RD1:  n_state = kspd_pkg::S_RD2;
            kspd_pkg::S_RD2:  n_state = kspd_pkg::S_RD3;
            kspd_pkg::S_RD3:  n_state = kspd_pkg::S_RD4;
            kspd_pkg::S_RD4:  n_state = kspd_pkg::S_C0;
            kspd_pkg::S_C0:   if (i_stat.arith_done) n_state = kspd_pkg::S_C1;
            kspd_pkg::S_C1:   if (i_stat.arith_done) n_state = kspd_pkg::S_C2;
            kspd_pkg::S_C2:   if (i_stat.arith_done) n_state = kspd_pkg::S_DL;
            kspd_pkg::S_DL:   if (i_stat.arith_done) n_state = kspd_pkg::S_PREP;
            kspd_pkg::S_PREP: n_state = kspd_pkg::S_LOM;
            kspd_pkg::S_LOM:  if (i_stat.arith_done) n_state = kspd_pkg::S_LOD;
            kspd_pkg::S_LOD:  if (i_stat.arith_done) n_state = kspd_pkg::S_UPM;
            kspd_pkg::S_UPM:  if (i_stat.arith_done) n_state = kspd_pkg::S_UPD;
            kspd_pkg::S_UPD:  if (i_stat.arith_done) n_state = kspd_pkg::S_OUT;
            kspd_pkg::S_OUT:  if (i_stat.out_free) n_state = kspd_pkg::S_IDLE;
            default:          n_state = kspd_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = (r_state == kspd_pkg::S_IDLE);
        o_cmd.take  = o_in_ready && i_in_valid;
        o_cmd.start = is_op && !r_issued;
        case (r_state)
            kspd_pkg::S_SQ:   o_cmd.step = kspd_pkg::ST_SQ;
            kspd_pkg::S_RT:   o_cmd.step = kspd_pkg::ST_RT;
            kspd_pkg::S_XI:   o_cmd.step = kspd_pkg::ST_XI;
            kspd_pkg::S_SRCH: o_cmd.step = i_stat.search_done ? kspd_pkg::ST_NONE
                                                              : kspd_pkg::ST_SRD;
            kspd_pkg::S_SCMP: o_cmd.step = kspd_pkg::ST_SCMP;
            kspd_pkg::S_RD0:  o_cmd.step = kspd_pkg::ST_RD0;
            kspd_pkg::S_RD1:  o_cmd.step = kspd_pkg::ST_RD1;
            kspd_pkg::S_RD2:  o_cmd.step = kspd_pkg::ST_RD2;
            kspd_pkg::S_RD3:  o_cmd.step = kspd_pkg::ST_RD3;
            kspd_pkg::S_RD4:  o_cmd.step = kspd_pkg::ST_RD4;
            kspd_pkg::S_C0:   o_cmd.step = kspd_pkg::ST_C0;
            kspd_pkg::S_C1:   o_cmd.step = kspd_pkg::ST_C1;
            kspd_pkg::S_C2:   o_cmd.step = kspd_pkg::ST_C2;
            kspd_pkg::S_DL:   o_cmd.step = kspd_pkg::ST_DL;
            kspd_pkg::S_PREP: o_cmd.step = kspd_pkg::ST_PREP;
            kspd_pkg::S_LOM:  o_cmd.step = kspd_pkg::ST_LOM;
            kspd_pkg::S_LOD:  o_cmd.step = kspd_pkg::ST_LOD;
            kspd_pkg::S_UPM:  o_cmd.step = kspd_pkg::ST_UPM;
            kspd_pkg::S_UPD:  o_cmd.step = kspd_pkg::ST_UPD;
            kspd_pkg::S_OUT:  o_cmd.step = i_stat.out_free ? kspd_pkg::ST_OUT
                                                           : kspd_pkg::ST_NONE;
            default:          o_cmd.step = kspd_pkg::ST_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kspd_pkg::S_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

endmodule

// File: rtl/knockon_source_pitch_deposit.sv
// Knock-on source pitch deposit. A load beat (kind 0) writes one grid point. An evaluate
// beat (kind 1) runs through one shared iterative unit, which does three 64-step
// multiplies, a 64-step square root and seven 96-step divides (a divide on a zero
// divisor stops after its first step), plus a search of the table and table reads in
// states RD0 to RD4. Input is ready only between items; a finished result waits in the
// output register while the next item is taken, and a result still waiting there stalls
// the next one at its end.
// Uses kspd_pkg, kspd_ctrl and kspd_datapath.
module knockon_source_pitch_deposit #(
    parameter int MAX_PITCH_POINTS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kspd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [62:0]                      i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_kind,
    input  logic [7:0]                       i_grid_index,
    input  logic signed [33:0]               i_grid_value,
    input  logic [62:0]                      i_momentum,
    input  logic [15:0]                      i_velocity_slot,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [15:0]                      o_slot_out,
    output logic [7:0]                       o_lower_cell,
    output logic signed [63:0]               o_lower_source,
    output logic signed [63:0]               o_upper_source,
    output logic                             o_saturated,
    output logic                             o_positive_pitch
);

    kspd_pkg::t_cmd  cmd;
    kspd_pkg::t_stat stat;

    kspd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    kspd_datapath #(
        .MAX_PITCH_POINTS (MAX_PITCH_POINTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_grid_index     (i_grid_index),
        .i_grid_value     (i_grid_value),
        .i_momentum       (i_momentum),
        .i_velocity_slot  (i_velocity_slot),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_slot_out       (o_slot_out),
        .o_lower_cell     (o_lower_cell),
        .o_lower_source   (o_lower_source),
        .o_upper_source   (o_upper_source),
        .o_saturated      (o_saturated),
        .o_positive_pitch (o_positive_pitch)
    );

endmodule

// File: rtl/kspd_checker.sv
// Port-level checks for knockon_source_pitch_deposit, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module kspd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               i_kind,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [63:0] o_lower_source,
    input logic signed [63:0] o_upper_source
);

    // result beat holds while stalled
    `KSPD_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_lower_source) && $stable(o_upper_source), "result beat dropped or changed while stalled")

    // a load beat never makes a result
    `KSPD_ASSERT_RST(a_load_quiet, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_kind && !o_out_valid |=> !o_out_valid, "load beat produced a result")

    // an evaluate beat keeps the input closed while it runs
    `KSPD_ASSERT_RST(a_eval_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_kind |=> !o_in_ready, "input open right after evaluate beat")

    // reset empties the output register
    `KSPD_ASSERT_ALL(a_rst_clear, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind knockon_source_pitch_deposit kspd_checker u_kspd_checker (.*);
